// ===== rtl/mha_pkg.sv =====
package mha_pkg;

	// Default count of angle steps; the cell chain is this plus a fixed margin
	localparam int MHA_ANGLE_STEPS = 16;
	localparam int CELL_MARGIN     = 8;

	// Magnitude of a 16-bit sample, which reaches 32768
	localparam int MAG_W = 17;

	// Angle word: centidegrees with ZF fraction bits, signed
	localparam int ZF    = 20;
	localparam int Z_W   = 1 + 13 + ZF;
	localparam int PHI_W = 13 + ZF;
	localparam int A_W   = 16 + ZF;
	localparam int CD_W  = 16;

	// Fixed angles in centidegrees, scaled by 2^ZF
	localparam logic [A_W-1:0] C_045  = A_W'(64'd4500 << ZF);
	localparam logic [A_W-1:0] C_090  = A_W'(64'd9000 << ZF);
	localparam logic [A_W-1:0] C_180  = A_W'(64'd18000 << ZF);
	localparam logic [A_W-1:0] C_360  = A_W'(64'd36000 << ZF);
	localparam logic [A_W-1:0] C_HALF = A_W'(64'd1 << (ZF - 1));

	localparam logic [CD_W-1:0] C_FULL_CD = CD_W'(36000);

	// Centidegrees per radian
	localparam real CD_PER_RAD = 18000.0 / 3.14159265358979323846;

	// Octant and quadrant of the sample, carried beside the datapath
	typedef struct packed {
		logic zero;
		logic swap;
		logic neg_x;
		logic neg_y;
	} fold_t;

	// atan(2^-i) in centidegrees, scaled by 2^ZF, rounded
	function automatic logic signed [Z_W-1:0] step_angle(input int i);
		real r;
		longint v;
		r = $atan(2.0 ** (-i)) * CD_PER_RAD;
		r = r * (2.0 ** ZF);
		v = longint'(r);
		return Z_W'(v);
	endfunction

endpackage

// ===== rtl/mha_fold.sv =====
module mha_fold
	import mha_pkg::*;
#(
	parameter int GUARD = MHA_ANGLE_STEPS + CELL_MARGIN + 4,
	parameter int XY_W  = MAG_W + GUARD + 2
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   en,
	input  logic                   valid_i,
	input  logic signed [15:0]     fx_i,
	input  logic signed [15:0]     fy_i,
	output logic                   valid_o,
	output fold_t                  fold_o,
	output logic signed [XY_W-1:0] x_o,
	output logic signed [XY_W-1:0] y_o
);

	logic [MAG_W-1:0] ax, ay, big, small_mag;
	logic             swap;
	logic             valid_s1;
	fold_t            fold_s1;
	logic [XY_W-1:0]  x_s1, y_s1;

	// Take magnitudes and fold into the first octant
	always_comb begin
		ax = fx_i[15] ? (MAG_W'(0) - {fx_i[15], fx_i}) : {fx_i[15], fx_i};
		ay = fy_i[15] ? (MAG_W'(0) - {fy_i[15], fy_i}) : {fy_i[15], fy_i};
		swap = (ay > ax);
		big       = swap ? ay : ax;
		small_mag = swap ? ax : ay;
	end

	// Hold control under reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= valid_i;
		end
	end

	// Scale up by the guard bits so small samples keep resolution
	always_ff @(posedge clk) begin
		if (en) begin
			fold_s1.zero  <= (ax == MAG_W'(0)) && (ay == MAG_W'(0));
			fold_s1.swap  <= swap;
			fold_s1.neg_x <= fx_i[15];
			fold_s1.neg_y <= fy_i[15];
			x_s1 <= XY_W'({big, GUARD'(0)});
			y_s1 <= XY_W'({small_mag, GUARD'(0)});
		end
	end

	assign valid_o = valid_s1;
	assign fold_o  = fold_s1;
	assign x_o     = $signed(x_s1);
	assign y_o     = $signed(y_s1);

endmodule

// ===== rtl/mha_cell.sv =====
module mha_cell
	import mha_pkg::*;
#(
	parameter int XY_W = MAG_W + MHA_ANGLE_STEPS + CELL_MARGIN + 6,
	parameter int STEP = 0
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   en,
	input  logic                   valid_i,
	input  fold_t                  fold_i,
	input  logic signed [XY_W-1:0] x_i,
	input  logic signed [XY_W-1:0] y_i,
	input  logic signed [Z_W-1:0]  z_i,
	output logic                   valid_o,
	output fold_t                  fold_o,
	output logic signed [XY_W-1:0] x_o,
	output logic signed [XY_W-1:0] y_o,
	output logic signed [Z_W-1:0]  z_o
);

	localparam logic signed [Z_W-1:0] ANG = step_angle(STEP);

	logic signed [XY_W-1:0] dx, dy, x_n, y_n;
	logic signed [Z_W-1:0]  z_n;
	logic                   valid_q;
	fold_t                  fold_q;
	logic signed [XY_W-1:0] x_q, y_q;
	logic signed [Z_W-1:0]  z_q;

	// Rotate toward the x axis by atan(2^-STEP)
	always_comb begin
		dx = y_i >>> STEP;
		dy = x_i >>> STEP;
		if (!y_i[XY_W-1]) begin
			x_n = x_i + dx;
			y_n = y_i - dy;
			z_n = z_i + ANG;
		end else begin
			x_n = x_i - dx;
			y_n = y_i + dy;
			z_n = z_i - ANG;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= valid_i;
		end
	end

	// Hand the rotated vector to the next cell
	always_ff @(posedge clk) begin
		if (en) begin
			fold_q <= fold_i;
			x_q    <= x_n;
			y_q    <= y_n;
			z_q    <= z_n;
		end
	end

	assign valid_o = valid_q;
	assign fold_o  = fold_q;
	assign x_o     = x_q;
	assign y_o     = y_q;
	assign z_o     = z_q;

endmodule

// ===== rtl/mha_unfold.sv =====
module mha_unfold
	import mha_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  en,
	input  logic                  valid_i,
	input  fold_t                 fold_i,
	input  logic signed [Z_W-1:0] z_i,
	output logic                  valid_o,
	output logic [CD_W-1:0]       cd_o
);

	logic [PHI_W-1:0] phi;
	logic [A_W-1:0]   oct_a, quad_a, rnd_sum;
	logic [CD_W-1:0]  rnd, wrapped;
	logic             over;

	logic             valid_s1, valid_s2, valid_s3;
	fold_t            fold_s1, fold_s2;
	logic [A_W-1:0]   oct_s1, quad_s2;
	logic [CD_W-1:0]  cd_s3;

	// Clamp to 0..45 degrees and undo the octant swap
	always_comb begin
		over = !z_i[Z_W-1] && (z_i > $signed(Z_W'(C_045)));
		if (z_i[Z_W-1]) begin
			phi = PHI_W'(0);
		end else if (over) begin
			phi = PHI_W'(C_045);
		end else begin
			phi = z_i[PHI_W-1:0];
		end
		oct_a = fold_i.swap ? (C_090 - A_W'(phi)) : A_W'(phi);
	end

	// Place the angle in its quadrant
	always_comb begin
		if (!fold_s1.neg_x && !fold_s1.neg_y) begin
			quad_a = oct_s1;
		end else if (fold_s1.neg_x && !fold_s1.neg_y) begin
			quad_a = C_180 - oct_s1;
		end else if (fold_s1.neg_x) begin
			quad_a = C_180 + oct_s1;
		end else begin
			quad_a = C_360 - oct_s1;
		end
	end

	// Round to a centidegree, wrap a full turn to zero and give 0 for a zero sample
	always_comb begin
		rnd_sum = quad_s2 + C_HALF;
		rnd     = rnd_sum[A_W-1:ZF];
		wrapped = (rnd >= C_FULL_CD) ? (rnd - C_FULL_CD) : rnd;
		if (fold_s2.zero) begin
			wrapped = CD_W'(0);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else if (en) begin
			valid_s1 <= valid_i;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			fold_s1 <= fold_i;
			oct_s1  <= oct_a;
			fold_s2 <= fold_s1;
			quad_s2 <= quad_a;
			cd_s3   <= wrapped;
		end
	end

	assign valid_o = valid_s3;
	assign cd_o    = cd_s3;

endmodule

// ===== rtl/mha_out_buf.sv =====
module mha_out_buf
	import mha_pkg::*;
(
	input  logic            clk,
	input  logic            arst_n,
	input  logic            valid_i,
	input  logic [CD_W-1:0] data_i,
	output logic            en,
	output logic            out_valid,
	input  logic            out_ready,
	output logic [CD_W-1:0] out_data
);

	logic            out_valid_q, skid_valid_q;
	logic [CD_W-1:0] out_data_q, skid_data_q;
	logic            take;

	// Advance the pipeline while the skid slot is free
	assign en   = !skid_valid_q;
	assign take = out_ready || !out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (take) begin
			if (skid_valid_q) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q <= valid_i;
			end
		end else if (valid_i && !skid_valid_q) begin
			skid_valid_q <= 1'b1;
		end
	end

	// Move the request into the output or park it in the skid slot
	always_ff @(posedge clk) begin
		if (take) begin
			out_data_q <= skid_valid_q ? skid_data_q : data_i;
		end else if (valid_i && !skid_valid_q) begin
			skid_data_q <= data_i;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule

// ===== rtl/magnetic_heading_atan2_core.sv =====
// Compass heading from one X/Y magnetometer sample.
// Input channel: in_valid/in_ready with field_x and field_y, signed 16-bit.
// Output channel: out_valid/out_ready with heading_centideg, 0..35999 in
// hundredths of a degree, counted from +X toward +Y; a zero sample gives 0.
// The sample is folded into the first octant, passed through a chain of
// ANGLE_STEPS+8 CORDIC cells in vectoring mode, then mapped back to the full
// circle and rounded to the nearest centidegree.
// Stages from accepted request to out_valid: one fold stage, one register
// per cell, three unfold stages and the output register.
// Throughput: one request per cycle while in_ready is high.
// When the receiver stalls, the next result to arrive moves into a one-entry
// skid slot and in_ready drops the cycle after; the pipeline then holds until
// out_ready frees the slot. Nothing is lost or repeated.
// Reset clears all valid flags; the block is ready at once after reset.
module magnetic_heading_atan2_core
	import mha_pkg::*;
#(
	parameter int ANGLE_STEPS = MHA_ANGLE_STEPS
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [15:0] field_x,
	input  logic signed [15:0] field_y,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [15:0]        heading_centideg
);

	localparam int CELLS = ANGLE_STEPS + CELL_MARGIN;
	localparam int GUARD = CELLS + 4;
	localparam int XY_W  = MAG_W + GUARD + 2;

	logic                   en;
	logic                   valid_c [0:CELLS];
	fold_t                  fold_c  [0:CELLS];
	logic signed [XY_W-1:0] x_c     [0:CELLS];
	logic signed [XY_W-1:0] y_c     [0:CELLS];
	logic signed [Z_W-1:0]  z_c     [0:CELLS];
	logic                   res_valid;
	logic [CD_W-1:0]        res_cd;

	assign in_ready = en;

	// Fold the sample into the first octant
	mha_fold #(
		.GUARD (GUARD),
		.XY_W  (XY_W)
	) u_fold (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.valid_i (in_valid),
		.fx_i    (field_x),
		.fy_i    (field_y),
		.valid_o (valid_c[0]),
		.fold_o  (fold_c[0]),
		.x_o     (x_c[0]),
		.y_o     (y_c[0])
	);

	assign z_c[0] = Z_W'(0);

	// Chain of rotation cells
	for (genvar i = 0; i < CELLS; i++) begin : g_cell
		mha_cell #(
			.XY_W (XY_W),
			.STEP (i)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.en      (en),
			.valid_i (valid_c[i]),
			.fold_i  (fold_c[i]),
			.x_i     (x_c[i]),
			.y_i     (y_c[i]),
			.z_i     (z_c[i]),
			.valid_o (valid_c[i+1]),
			.fold_o  (fold_c[i+1]),
			.x_o     (x_c[i+1]),
			.y_o     (y_c[i+1]),
			.z_o     (z_c[i+1])
		);
	end

	// Map back to the full circle and round
	mha_unfold u_unfold (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.valid_i (valid_c[CELLS]),
		.fold_i  (fold_c[CELLS]),
		.z_i     (z_c[CELLS]),
		.valid_o (res_valid),
		.cd_o    (res_cd)
	);

	// Output register with skid slot
	mha_out_buf u_out_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.valid_i   (res_valid),
		.data_i    (res_cd),
		.en        (en),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (heading_centideg)
	);

endmodule

// ===== rtl/mha_checker.sv =====
module mha_checker
	import mha_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [15:0] heading_centideg
);

	// A stalled result holds its value
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(heading_centideg))
		else $error("stalled heading changed or dropped");

	// Heading stays below a full turn
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> heading_centideg < C_FULL_CD)
		else $error("heading out of range");

	// Input backpressure only while a result waits at the output
	a_ready_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid)
		else $error("in_ready low with empty output");

	// in_ready drops only after the receiver stalled
	a_ready_fall: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(in_ready) |-> $past(out_valid && !out_ready))
		else $error("in_ready fell without an output stall");

endmodule

bind magnetic_heading_atan2_core mha_checker u_mha_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.in_ready         (in_ready),
	.out_valid        (out_valid),
	.out_ready        (out_ready),
	.heading_centideg (heading_centideg)
);
